[hw/rtl/ltln_pkg.sv]
package ltln_pkg;

    localparam int QW  = 16;
    localparam int SW  = 40;
    localparam int MW  = 17;
    localparam int PW  = 2 * MW;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t CFG_THRESHOLD = 2'd0;
    localparam cfg_index_t CFG_MAX_VALUE = 2'd1;
    localparam cfg_index_t CFG_INV_TAU   = 2'd2;
    localparam cfg_index_t CFG_UNIT_BASE = 2'd3;

    typedef struct packed {
        logic signed [QW-1:0] threshold;
        logic signed [QW-1:0] max_value;
        logic        [QW-1:0] inv_tau;
        logic        [QW-1:0] unit_base;
    } ltln_cfg_t;

endpackage

[hw/rtl/leaky_threshold_linear_neuron.sv]
// Channel   Handshake            Payload
// s_        s_valid / s_ready    s_unit_id, s_term_valid, s_term_value, s_term_weight, s_last
// m_        m_valid / m_ready    m_out_unit, m_out_value, m_out_of_range
// cfg_      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A term without last takes the idle and accumulate steps; an item with last goes on through
// read, leak, update and result, skipping leak and update when its unit is outside the store,
// as the sequencer passes the shared 17x17 multiplier and the potential RAM port in turn.
// After reset the potential RAM is cleared one entry per cycle, all UNITS entries in turn,
// with s_ready low. The result register lets the sequencer run on while a result
// waits; only a last item stalls, in its final step, until the result register is free.
module leaky_threshold_linear_neuron #(
    parameter int UNITS = 256
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  ltln_pkg::cfg_index_t        cfg_index,
    input  logic [15:0]                 cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [15:0]                 s_unit_id,
    input  logic                        s_term_valid,
    input  logic signed [15:0]          s_term_value,
    input  logic signed [15:0]          s_term_weight,
    input  logic                        s_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [15:0]                 m_out_unit,
    output logic signed [15:0]          m_out_value,
    output logic                        m_out_of_range
);

    import ltln_pkg::*;

    localparam int AW = (UNITS > 1) ? $clog2(UNITS) : 1;

    ltln_cfg_t            cfg_reg, cfg_next;
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic                 ram_wr_en;
    logic [AW-1:0]        ram_wr_addr;
    logic [15:0]          ram_wr_data;
    logic [AW-1:0]        ram_rd_addr;
    logic [15:0]          ram_rd_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_THRESHOLD: cfg_next.threshold = cfg_data;
                CFG_MAX_VALUE: cfg_next.max_value = cfg_data;
                CFG_INV_TAU:   cfg_next.inv_tau   = cfg_data;
                CFG_UNIT_BASE: cfg_next.unit_base = cfg_data;
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold <= 16'sd256;
            cfg_reg.max_value <= -16'sd256;
            cfg_reg.inv_tau   <= 16'd6554;
            cfg_reg.unit_base <= 16'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ltln_ctrl #(
        .UNITS(UNITS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_unit_id     (s_unit_id),
        .s_term_valid  (s_term_valid),
        .s_term_value  (s_term_value),
        .s_term_weight (s_term_weight),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_unit    (m_out_unit),
        .m_out_value   (m_out_value),
        .m_out_of_range(m_out_of_range),
        .mul_a         (mul_a),
        .mul_b         (mul_b),
        .prod          (prod),
        .ram_wr_en     (ram_wr_en),
        .ram_wr_addr   (ram_wr_addr),
        .ram_wr_data   (ram_wr_data),
        .ram_rd_addr   (ram_rd_addr),
        .ram_rd_data   (ram_rd_data)
    );

    ltln_mul u_mul (
        .aclk    (aclk),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .prod_reg(prod)
    );

    ltln_ram #(
        .WIDTH(16),
        .DEPTH(UNITS)
    ) u_potential_ram (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

endmodule

[hw/rtl/ltln_ram.sv]
module ltln_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[hw/rtl/ltln_mul.sv]
module ltln_mul (
    input  logic                            aclk,
    input  logic signed [ltln_pkg::MW-1:0]  mul_a,
    input  logic signed [ltln_pkg::MW-1:0]  mul_b,
    output logic signed [ltln_pkg::PW-1:0]  prod_reg
);

    import ltln_pkg::*;

    logic signed [PW-1:0] prod_next;

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

[hw/rtl/ltln_ctrl.sv]
module ltln_ctrl #(
    parameter int UNITS = 256,
    localparam int AW = (UNITS > 1) ? $clog2(UNITS) : 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ltln_pkg::ltln_cfg_t             cfg,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [15:0]                     s_unit_id,
    input  logic                            s_term_valid,
    input  logic signed [15:0]              s_term_value,
    input  logic signed [15:0]              s_term_weight,
    input  logic                            s_last,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [15:0]                     m_out_unit,
    output logic signed [15:0]              m_out_value,
    output logic                            m_out_of_range,
    output logic signed [ltln_pkg::MW-1:0]  mul_a,
    output logic signed [ltln_pkg::MW-1:0]  mul_b,
    input  logic signed [ltln_pkg::PW-1:0]  prod,
    output logic                            ram_wr_en,
    output logic [AW-1:0]                   ram_wr_addr,
    output logic [15:0]                     ram_wr_data,
    output logic [AW-1:0]                   ram_rd_addr,
    input  logic [15:0]                     ram_rd_data
);

    import ltln_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC,
        ST_READ,
        ST_LEAK,
        ST_UPD,
        ST_RES
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic signed [SW-1:0] term_sum_reg, term_sum_next;
    logic [15:0]          uid_reg, uid_next;
    logic                 tv_reg, tv_next;
    logic                 last_reg, last_next;
    logic signed [15:0]   xt_reg, xt_next;
    logic signed [15:0]   p_reg, p_next;
    logic signed [15:0]   np_reg, np_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic                 oor_reg, oor_next;
    logic                 m_valid_reg, m_valid_next;
    logic [15:0]          m_unit_reg, m_unit_next;
    logic signed [15:0]   m_value_reg, m_value_next;
    logic                 m_oor_reg, m_oor_next;

    logic signed [SW:0]   acc_wide;
    logic signed [SW-1:0] acc_sat;
    logic signed [31:0]   sum_shift;
    logic signed [15:0]   xt_sat;
    logic [16:0]          idx_diff;
    logic                 idx_oor;
    logic signed [16:0]   leak_diff;
    logic signed [18:0]   np_wide;
    logic signed [15:0]   np_sat;
    logic signed [16:0]   res_diff;
    logic                 fire;
    logic signed [15:0]   res_sat;
    logic signed [15:0]   res_clamp;
    logic signed [15:0]   res_final;
    logic                 out_free;

    // Term accumulation with saturation at the 40-bit limits.
    always_comb begin
        acc_wide = $signed({term_sum_reg[SW-1], term_sum_reg})
                 + $signed({{(SW + 1 - PW){prod[PW-1]}}, prod});
        if (acc_wide[SW] != acc_wide[SW-1]) begin
            acc_sat = acc_wide[SW] ? $signed({1'b1, {(SW - 1){1'b0}}})
                                   : $signed({1'b0, {(SW - 1){1'b1}}});
        end else begin
            acc_sat = acc_wide[SW-1:0];
        end
    end

    // The arithmetic shift rounds the sum down to Q8.8 before saturation.
    always_comb begin
        sum_shift = term_sum_reg[SW-1:8];
        if (sum_shift[31:15] != {17{sum_shift[31]}}) begin
            xt_sat = sum_shift[31] ? 16'sh8000 : 16'sh7fff;
        end else begin
            xt_sat = sum_shift[15:0];
        end
    end

    assign idx_diff  = {1'b0, uid_reg} - {1'b0, cfg.unit_base};
    assign idx_oor   = idx_diff[16] || ({1'b0, idx_diff[15:0]} >= 17'(UNITS));
    assign leak_diff = $signed({xt_reg[15], xt_reg}) - $signed({ram_rd_data[15], ram_rd_data});

    always_comb begin
        np_wide = $signed({{3{p_reg[15]}}, p_reg}) + $signed({prod[PW-1], prod[PW-1:16]});
        if (np_wide[18:15] != {4{np_wide[18]}}) begin
            np_sat = np_wide[18] ? 16'sh8000 : 16'sh7fff;
        end else begin
            np_sat = np_wide[15:0];
        end
    end

    always_comb begin
        res_diff = $signed({np_reg[15], np_reg}) - $signed({cfg.threshold[15], cfg.threshold});
        fire     = !res_diff[16] && (res_diff != 17'sd0);
        res_sat  = res_diff[15] ? 16'sh7fff : res_diff[15:0];
        if ((cfg.max_value > 16'sd0) && (res_sat > cfg.max_value)) begin
            res_clamp = cfg.max_value;
        end else begin
            res_clamp = res_sat;
        end
        res_final = (oor_reg || !fire) ? 16'sd0 : res_clamp;
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        mul_a = (state_reg == ST_LEAK) ? leak_diff : $signed({s_term_value[15], s_term_value});
        mul_b = (state_reg == ST_LEAK) ? $signed({1'b0, cfg.inv_tau})
                                       : $signed({s_term_weight[15], s_term_weight});
    end

    assign ram_rd_addr = idx_diff[AW-1:0];

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        term_sum_next = term_sum_reg;
        uid_next      = uid_reg;
        tv_next       = tv_reg;
        last_next     = last_reg;
        xt_next       = xt_reg;
        p_next        = p_reg;
        np_next       = np_reg;
        idx_next      = idx_reg;
        oor_next      = oor_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_unit_next   = m_unit_reg;
        m_value_next  = m_value_reg;
        m_oor_next    = m_oor_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = idx_reg;
        ram_wr_data   = np_sat;
        s_ready       = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = clr_cnt_reg;
                ram_wr_data  = 16'd0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(UNITS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    uid_next   = s_unit_id;
                    tv_next    = s_term_valid;
                    last_next  = s_last;
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                if (tv_reg) begin
                    term_sum_next = acc_sat;
                end
                state_next = last_reg ? ST_READ : ST_IDLE;
            end
            ST_READ: begin
                xt_next       = xt_sat;
                term_sum_next = '0;
                idx_next      = idx_diff[AW-1:0];
                oor_next      = idx_oor;
                state_next    = idx_oor ? ST_RES : ST_LEAK;
            end
            ST_LEAK: begin
                p_next     = ram_rd_data;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                np_next    = np_sat;
                ram_wr_en  = 1'b1;
                state_next = ST_RES;
            end
            ST_RES: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_unit_next  = uid_reg;
                    m_value_next = res_final;
                    m_oor_next   = oor_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            term_sum_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            term_sum_reg <= term_sum_next;
            m_valid_reg  <= m_valid_next;
        end
        uid_reg     <= uid_next;
        tv_reg      <= tv_next;
        last_reg    <= last_next;
        xt_reg      <= xt_next;
        p_reg       <= p_next;
        np_reg      <= np_next;
        idx_reg     <= idx_next;
        oor_reg     <= oor_next;
        m_unit_reg  <= m_unit_next;
        m_value_reg <= m_value_next;
        m_oor_reg   <= m_oor_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_out_unit     = m_unit_reg;
    assign m_out_value    = m_value_reg;
    assign m_out_of_range = m_oor_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item was in flight");

    a_result_from_res: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_RES))
        else $error("result issued outside the result step");

    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_oor_reg) |-> (m_value_reg == 16'sd0))
        else $error("out-of-range result carries a nonzero value");
`endif

endmodule

[verif/leaky_threshold_linear_neuron_tb.sv]
`timescale 1ns / 100ps

module leaky_threshold_linear_neuron_tb;
    import ltln_pkg::*;

    localparam int UNITS = 256;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SATURATING_TERMS = 520;
    localparam longint SUM_MAX = (longint'(1) <<< 39) - 1;
    localparam longint SUM_MIN = -(longint'(1) <<< 39);

    typedef struct packed {
        logic [15:0]        unit_id;
        logic               term_valid;
        logic signed [15:0] term_value;
        logic signed [15:0] term_weight;
        logic               last;
    } neuron_term_t;

    typedef struct packed {
        logic [15:0]        unit;
        logic signed [15:0] value;
        logic               out_of_range;
    } neuron_output_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    cfg_index_t         cfg_index = CFG_THRESHOLD;
    logic [15:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [15:0]        s_unit_id = '0;
    logic               s_term_valid = 1'b0;
    logic signed [15:0] s_term_value = '0;
    logic signed [15:0] s_term_weight = '0;
    logic               s_last = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [15:0]        m_out_unit;
    logic signed [15:0] m_out_value;
    logic               m_out_of_range;

    // Predictor state, kept in step with the register writes seen on the bus.
    logic signed [15:0] threshold_q = 16'sd256;
    logic signed [15:0] max_value_q = -16'sd256;
    logic [15:0]        inv_tau_q = 16'd6554;
    logic [15:0]        unit_base_q = 16'd0;
    longint             term_sum_q = 0;
    logic signed [15:0] potential_q [UNITS];

    neuron_term_t   term_queue [$];
    neuron_output_t unit_outputs [$];
    neuron_term_t   next_term;
    neuron_term_t   accepted_term;
    neuron_output_t predicted;
    neuron_output_t oldest;

    int  send_gap_pct = 0;
    int  recv_gap_pct = 0;
    int  hold_len = 0;
    int  hold_count = 0;
    bit  s_took = 1'b0;
    int  errors = 0;
    int  terms_sent = 0;
    int  outputs_checked = 0;
    int  outputs_fired = 0;
    int  outputs_outside = 0;
    int  cycle_count = 0;

    leaky_threshold_linear_neuron #(
        .UNITS(UNITS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_unit_id(s_unit_id),
        .s_term_valid(s_term_valid),
        .s_term_value(s_term_value),
        .s_term_weight(s_term_weight),
        .s_last(s_last),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_unit(m_out_unit),
        .m_out_value(m_out_value),
        .m_out_of_range(m_out_of_range)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic bit integrate_term(input neuron_term_t t, output neuron_output_t r);
        longint             idx;
        longint             np;
        longint             fire;
        logic signed [15:0] xt;
        logic signed [15:0] p;
        if (t.term_valid) begin
            term_sum_q = term_sum_q + longint'(t.term_value) * longint'(t.term_weight);
            if (term_sum_q > SUM_MAX) term_sum_q = SUM_MAX;
            if (term_sum_q < SUM_MIN) term_sum_q = SUM_MIN;
        end
        if (!t.last) return 1'b0;
        xt = clamp16(term_sum_q >>> 8);
        term_sum_q = 0;
        idx = longint'(t.unit_id) - longint'(unit_base_q);
        r.unit = t.unit_id;
        r.value = '0;
        r.out_of_range = 1'b0;
        if (idx < 0 || idx >= UNITS) begin
            r.out_of_range = 1'b1;
        end else begin
            p = potential_q[idx];
            np = longint'(p) + (((longint'(xt) - longint'(p)) * longint'(inv_tau_q)) >>> 16);
            np = clamp16(np);
            potential_q[idx] = np[15:0];
            if (np > threshold_q) begin
                fire = clamp16(np - threshold_q);
                if (max_value_q > 0 && fire > max_value_q) fire = max_value_q;
                r.value = fire[15:0];
            end
        end
        return 1'b1;
    endfunction

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || s_took)) begin
            if (term_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                next_term = term_queue.pop_front();
                s_unit_id <= next_term.unit_id;
                s_term_valid <= next_term.term_valid;
                s_term_value <= next_term.term_value;
                s_term_weight <= next_term.term_weight;
                s_last <= next_term.last;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_count < hold_len) begin
            m_ready <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    always @(posedge aclk) begin
        s_took = 1'b0;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_THRESHOLD: threshold_q = cfg_data;
                    CFG_MAX_VALUE: max_value_q = cfg_data;
                    CFG_INV_TAU:   inv_tau_q = cfg_data;
                    CFG_UNIT_BASE: unit_base_q = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                s_took = 1'b1;
                terms_sent++;
                accepted_term = {s_unit_id, s_term_valid, s_term_value, s_term_weight, s_last};
                if (integrate_term(accepted_term, predicted)) begin
                    unit_outputs.insert(unit_outputs.size(), predicted);
                end
            end
            if (m_valid && m_ready) begin
                if (unit_outputs.size() == 0) begin
                    errors++;
                    $display("%0t: output for unit %0d value %0d with none expected",
                             $time, m_out_unit, m_out_value);
                end else begin
                    oldest = unit_outputs.pop_front();
                    outputs_checked++;
                    if (oldest.value != 0) outputs_fired++;
                    if (oldest.out_of_range) outputs_outside++;
                    if (m_out_unit !== oldest.unit) begin
                        errors++;
                        $display("%0t: out_unit expected %0d, actual %0d",
                                 $time, oldest.unit, m_out_unit);
                    end
                    if (m_out_value !== oldest.value) begin
                        errors++;
                        $display("%0t: out_value for unit %0d expected %0d, actual %0d",
                                 $time, oldest.unit, oldest.value, m_out_value);
                    end
                    if (m_out_of_range !== oldest.out_of_range) begin
                        errors++;
                        $display("%0t: out_of_range for unit %0d expected %0b, actual %0b",
                                 $time, oldest.unit, oldest.out_of_range, m_out_of_range);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_term(input logic [15:0] uid, input logic tv,
                             input logic signed [15:0] val, input logic signed [15:0] wgt,
                             input logic lst);
        neuron_term_t t;
        t.unit_id = uid;
        t.term_valid = tv;
        t.term_value = val;
        t.term_weight = wgt;
        t.last = lst;
        term_queue.insert(term_queue.size(), t);
    endtask

    function automatic logic signed [15:0] pick_q();
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2, 3: return 16'($urandom);
            default: return 16'($urandom_range(1024)) - 16'd512;
        endcase
    endfunction

    // Most updates land on a handful of units so that potentials build up and fire.
    function automatic logic [15:0] pick_unit();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return unit_base_q + 16'($urandom_range(UNITS - 1));
            2: return unit_base_q + ($urandom_range(1) ? 16'(UNITS) : 16'hffff);
            3: return unit_base_q + 16'(UNITS - 1);
            default: return unit_base_q + 16'($urandom_range(7));
        endcase
    endfunction

    task automatic queue_random_updates(input int count);
        int          n;
        int          terms;
        logic [15:0] target;
        n = 0;
        while (n < count) begin
            terms = ($urandom_range(3) == 0) ? $urandom_range(12, 1) : $urandom_range(3, 1);
            target = pick_unit();
            for (int k = 0; k < terms; k++) begin
                push_term(($urandom_range(7) == 0) ? 16'($urandom) : target,
                          ($urandom_range(9) != 0), pick_q(), pick_q(), k == terms - 1);
            end
            n += terms;
        end
    endtask

    task automatic queue_saturating_sum(input logic signed [15:0] val,
                                        input logic signed [15:0] wgt);
        for (int k = 0; k < SATURATING_TERMS; k++) begin
            push_term(unit_base_q, 1'b1, val, wgt, k == SATURATING_TERMS - 1);
        end
    endtask

    task automatic wait_idle();
        while (term_queue.size() != 0 || s_valid || unit_outputs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic start_phase(input logic [15:0] thr, input logic [15:0] mx,
                               input logic [15:0] tau, input logic [15:0] base,
                               input int send_gap, input int recv_gap);
        wait_idle();
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_MAX_VALUE, mx);
        write_reg(CFG_INV_TAU, tau);
        write_reg(CFG_UNIT_BASE, base);
        send_gap_pct = send_gap;
        recv_gap_pct = recv_gap;
    endtask

    initial begin
        for (int i = 0; i < UNITS; i++) potential_q[i] = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        start_phase(16'h0100, 16'h0000, 16'hffff, 16'h0000, 31, 64);
        push_term(16'd0, 1'b0, 16'sh1234, 16'sh5678, 1'b1);
        push_term(16'd1, 1'b1, 16'sh7fff, 16'sh7fff, 1'b1);
        push_term(16'd2, 1'b1, 16'sh8000, 16'sh7fff, 1'b1);
        push_term(16'd255, 1'b1, 16'sh8000, 16'sh8000, 1'b1);
        push_term(16'd256, 1'b1, 16'sh0100, 16'sh0100, 1'b1);
        push_term(16'hffff, 1'b1, 16'sh7fff, 16'sh7fff, 1'b1);
        push_term(16'd3, 1'b1, 16'sh0100, 16'sh0200, 1'b0);
        push_term(16'd4, 1'b1, 16'sh0300, 16'shff00, 1'b0);
        push_term(16'd5, 1'b1, 16'sh0080, 16'sh0100, 1'b1);
        push_term(16'd6, 1'b1, 16'sh0200, 16'sh0200, 1'b0);
        push_term(16'd6, 1'b0, 16'sh7fff, 16'sh7fff, 1'b0);
        push_term(16'd6, 1'b1, 16'shff80, 16'sh0100, 1'b1);
        push_term(16'd1, 1'b1, 16'sh7fff, 16'sh7fff, 1'b1);
        push_term(16'd7, 1'b1, 16'sh0100, 16'sh0100, 1'b1);
        push_term(16'd8, 1'b1, 16'shffff, 16'sh0001, 1'b1);
        push_term(16'd8, 1'b0, 16'sh0000, 16'sh0000, 1'b1);

        // A long stall on the output side lets the block back up into its input.
        start_phase(16'h8000, 16'h7fff, 16'h0001, 16'h0000, 31, 64);
        hold_len = 400;
        queue_random_updates(60);

        start_phase(16'h7fff, 16'h8000, 16'd6554, 16'hffff, 64, 31);
        queue_random_updates(40);

        start_phase(16'h0040, 16'h00c8, 16'h8000, 16'd100, 64, 31);
        queue_random_updates(50);
        wait_idle();
        queue_random_updates(50);

        start_phase(16'h0000, 16'h0001, 16'h0000, 16'h0000, 0, 0);
        queue_random_updates(30);

        start_phase(16'($urandom), 16'($urandom), 16'($urandom_range(65535, 1)),
                    16'($urandom), 0, 0);
        queue_saturating_sum(16'sh8000, 16'sh8000);
        queue_saturating_sum(16'sh8000, 16'sh7fff);
        queue_random_updates(70);

        wait_idle();
        $display("tb: %0d terms sent, %0d unit outputs checked (%0d fired, %0d out of range)",
                 terms_sent, outputs_checked, outputs_fired, outputs_outside);
        if (errors == 0 && unit_outputs.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/ltln_pkg.sv
hw/rtl/ltln_ram.sv
hw/rtl/ltln_mul.sv
hw/rtl/ltln_ctrl.sv
hw/rtl/leaky_threshold_linear_neuron.sv
verif/leaky_threshold_linear_neuron_tb.sv
